/* rtl/key_history_change_reporter_top_defines.svh */
// ----------------------------------------------------------------------------
// Key history change reporter: assertion macros
// Shared helpers for writing concurrent assertions on clk_i.
// ----------------------------------------------------------------------------
`ifndef KEY_HISTORY_CHANGE_REPORTER_TOP_DEFINES_SVH
`define KEY_HISTORY_CHANGE_REPORTER_TOP_DEFINES_SVH

// Checked on every rising edge of clk_i, switched off while rst_ni is low.
`define KH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, also during reset.
`define KH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/kh_pkg.sv */
// ----------------------------------------------------------------------------
// Key history change reporter: package
// Sizes, command codes and the types shared by the front and back parts.
// ----------------------------------------------------------------------------
package kh_pkg;

  localparam int KEYS      = 128;
  localparam int MAX_PAIRS = 16;

  localparam int FUNC_W = 3;
  localparam int KEY_W  = 8;
  localparam int HIST_W = 4;
  localparam int IDX_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int PAIR_W = $clog2(MAX_PAIRS + 1);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [HIST_W-1:0] HIST_ALL  = 4'hF;
  localparam logic [HIST_W-1:0] HIST_NONE = 4'h0;

  localparam logic [FUNC_W-1:0] FUNC_PRESS   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [2:0] {
    OP_PRESS,
    OP_RELEASE,
    OP_TICK,
    OP_READ,
    OP_CLEAR
  } op_e;

  // One classified command as it waits in the queue.
  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic             key_ok;
  } cmd_t;

  // One result beat as driven towards the output ports.
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic [HIST_W-1:0] hist;
    logic              ovf;
    logic              last;
  } res_t;

endpackage

/* rtl/kh_front.sv */
// ----------------------------------------------------------------------------
// Key history change reporter: front part
// Accepts commands, drops those that cannot change anything and queues the
// rest for the back part.
// ----------------------------------------------------------------------------
module kh_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kh_pkg::FUNC_W-1:0] func_i,
  input  logic [kh_pkg::KEY_W-1:0]  key_i,
  output logic                      busy_o,
  output logic                      q_valid_o,
  output kh_pkg::cmd_t              q_cmd_o,
  input  logic                      q_pop_i
);

  kh_pkg::cmd_t              fifo_q [kh_pkg::QDEPTH];
  logic [kh_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [kh_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [kh_pkg::QCNT_W-1:0] count_q, count_d;

  kh_pkg::cmd_t cmd;
  logic         keep;
  logic         push;

  // Classification: out-of-range press or release and unknown codes vanish.
  always_comb begin
    cmd.key    = key_i;
    cmd.key_ok = (int'(key_i) < kh_pkg::KEYS);
    cmd.op     = kh_pkg::OP_TICK;
    keep       = 1'b0;
    case (func_i)
      kh_pkg::FUNC_PRESS: begin
        cmd.op = kh_pkg::OP_PRESS;
        keep   = cmd.key_ok;
      end
      kh_pkg::FUNC_RELEASE: begin
        cmd.op = kh_pkg::OP_RELEASE;
        keep   = cmd.key_ok;
      end
      kh_pkg::FUNC_TICK: begin
        cmd.op = kh_pkg::OP_TICK;
        keep   = 1'b1;
      end
      kh_pkg::FUNC_READ: begin
        cmd.op = kh_pkg::OP_READ;
        keep   = 1'b1;
      end
      kh_pkg::FUNC_CLEAR: begin
        cmd.op = kh_pkg::OP_CLEAR;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy_o    = (count_q == kh_pkg::QCNT_W'(kh_pkg::QDEPTH));
  assign push      = start_i && !busy_o && keep;
  assign q_valid_o = (count_q != '0);
  assign q_cmd_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == kh_pkg::QPTR_W'(kh_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i && q_valid_o) begin
      rd_ptr_d = (rd_ptr_q == kh_pkg::QPTR_W'(kh_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !(q_pop_i && q_valid_o)) begin
      count_d = count_q + 1'b1;
    end else if (!push && q_pop_i && q_valid_o) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

/* rtl/kh_back.sv */
// ----------------------------------------------------------------------------
// Key history change reporter: back part
// Holds the history memory and the changed flag, and carries out queued
// commands: key updates, reads, clears and the tick walk over all keys.
// ----------------------------------------------------------------------------
module kh_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  kh_pkg::cmd_t q_cmd_i,
  output logic         q_pop_o,
  output kh_pkg::res_t res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_WALK
  } state_e;

  // History memory, one port written and one read per cycle.
  logic [kh_pkg::HIST_W-1:0] mem [kh_pkg::KEYS];
  logic [kh_pkg::HIST_W-1:0] rdata_q;
  logic                      rvld_q;
  logic [kh_pkg::KEYS-1:0]   vld_q;

  logic                      ren, we, clr;
  logic [kh_pkg::IDX_W-1:0]  raddr, waddr;
  logic [kh_pkg::HIST_W-1:0] wdata;
  logic [kh_pkg::HIST_W-1:0] hist_rd;
  logic [kh_pkg::HIST_W-1:0] hist_sh;
  logic                      qual;

  state_e                    state_q, state_d;
  kh_pkg::cmd_t              cur_q, cur_d;
  logic                      flag_q, flag_d;
  logic                      rpt_en_q, rpt_en_d;
  logic [kh_pkg::CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic                      proc_v_q, proc_v_d;
  logic [kh_pkg::IDX_W-1:0]  proc_idx_q, proc_idx_d;
  logic [kh_pkg::PAIR_W-1:0] cnt_q, cnt_d;
  logic                      pend_v_q, pend_v_d;
  logic [kh_pkg::IDX_W-1:0]  pend_key_q, pend_key_d;
  logic [kh_pkg::HIST_W-1:0] pend_hist_q, pend_hist_d;
  logic                      drop_q, drop_d;
  kh_pkg::res_t              res_q, res_d;

  // A never-written entry reads as zero.
  assign hist_rd = rvld_q ? rdata_q : kh_pkg::HIST_NONE;
  assign hist_sh = {hist_rd[2:0], 1'b0} | {3'b000, hist_rd[0]};
  assign qual    = (hist_rd != kh_pkg::HIST_ALL) && (hist_rd != kh_pkg::HIST_NONE);
  assign res_o   = res_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    flag_d      = flag_q;
    rpt_en_d    = rpt_en_q;
    rd_cnt_d    = rd_cnt_q;
    proc_v_d    = 1'b0;
    proc_idx_d  = proc_idx_q;
    cnt_d       = cnt_q;
    pend_v_d    = pend_v_q;
    pend_key_d  = pend_key_q;
    pend_hist_d = pend_hist_q;
    drop_d      = drop_q;
    res_d       = '0;
    q_pop_o     = 1'b0;
    ren         = 1'b0;
    raddr       = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    clr         = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_cmd_i;
          case (q_cmd_i.op)
            kh_pkg::OP_PRESS, kh_pkg::OP_RELEASE: begin
              ren     = 1'b1;
              raddr   = q_cmd_i.key[kh_pkg::IDX_W-1:0];
              state_d = ST_KEY;
            end
            kh_pkg::OP_READ: begin
              if (q_cmd_i.key_ok) begin
                ren     = 1'b1;
                raddr   = q_cmd_i.key[kh_pkg::IDX_W-1:0];
                state_d = ST_KEY;
              end else begin
                res_d.valid = 1'b1;
                res_d.kind  = kh_pkg::KIND_READ;
                res_d.key   = q_cmd_i.key;
                res_d.hist  = kh_pkg::HIST_NONE;
                res_d.last  = 1'b1;
              end
            end
            kh_pkg::OP_TICK: begin
              rpt_en_d = flag_q;
              flag_d   = 1'b0;
              rd_cnt_d = '0;
              cnt_d    = '0;
              pend_v_d = 1'b0;
              drop_d   = 1'b0;
              state_d  = ST_WALK;
            end
            kh_pkg::OP_CLEAR: begin
              clr    = 1'b1;
              flag_d = 1'b0;
            end
            default: begin
              clr = 1'b0;
            end
          endcase
        end
      end

      ST_KEY: begin
        state_d = ST_IDLE;
        case (cur_q.op)
          kh_pkg::OP_PRESS: begin
            if (!hist_rd[0]) begin
              we     = 1'b1;
              waddr  = cur_q.key[kh_pkg::IDX_W-1:0];
              wdata  = hist_rd | 4'b0001;
              flag_d = 1'b1;
            end
          end
          kh_pkg::OP_RELEASE: begin
            if (hist_rd[0]) begin
              we     = 1'b1;
              waddr  = cur_q.key[kh_pkg::IDX_W-1:0];
              wdata  = hist_rd & 4'b1110;
              flag_d = 1'b1;
            end
          end
          kh_pkg::OP_READ: begin
            res_d.valid = 1'b1;
            res_d.kind  = kh_pkg::KIND_READ;
            res_d.key   = cur_q.key;
            res_d.hist  = hist_rd;
            res_d.last  = 1'b1;
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end

      ST_WALK: begin
        // Read stage: one key per cycle.
        if (rd_cnt_q != kh_pkg::CNT_W'(kh_pkg::KEYS)) begin
          ren        = 1'b1;
          raddr      = rd_cnt_q[kh_pkg::IDX_W-1:0];
          rd_cnt_d   = rd_cnt_q + 1'b1;
          proc_v_d   = 1'b1;
          proc_idx_d = rd_cnt_q[kh_pkg::IDX_W-1:0];
        end
        // Process stage: shift the key read last cycle and look for a report.
        if (proc_v_q) begin
          we    = 1'b1;
          waddr = proc_idx_q;
          wdata = hist_sh;
          if (rpt_en_q && qual) begin
            if (cnt_q < kh_pkg::PAIR_W'(kh_pkg::MAX_PAIRS)) begin
              // The held report is not the final one, so it goes out now.
              if (pend_v_q) begin
                res_d.valid = 1'b1;
                res_d.kind  = kh_pkg::KIND_REPORT;
                res_d.key   = kh_pkg::KEY_W'(pend_key_q);
                res_d.hist  = pend_hist_q;
              end
              pend_v_d    = 1'b1;
              pend_key_d  = proc_idx_q;
              pend_hist_d = hist_rd;
              cnt_d       = cnt_q + 1'b1;
            end else begin
              drop_d = 1'b1;
            end
          end
        end else if (rd_cnt_q == kh_pkg::CNT_W'(kh_pkg::KEYS)) begin
          if (pend_v_q) begin
            res_d.valid = 1'b1;
            res_d.kind  = kh_pkg::KIND_REPORT;
            res_d.key   = kh_pkg::KEY_W'(pend_key_q);
            res_d.hist  = pend_hist_q;
            res_d.ovf   = drop_q;
            res_d.last  = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flag_q      <= 1'b0;
      rpt_en_q    <= 1'b0;
      rd_cnt_q    <= '0;
      proc_v_q    <= 1'b0;
      cnt_q       <= '0;
      pend_v_q    <= 1'b0;
      drop_q      <= 1'b0;
      res_q       <= '0;
      cur_q       <= '0;
      proc_idx_q  <= '0;
      pend_key_q  <= '0;
      pend_hist_q <= '0;
    end else begin
      state_q     <= state_d;
      flag_q      <= flag_d;
      rpt_en_q    <= rpt_en_d;
      rd_cnt_q    <= rd_cnt_d;
      proc_v_q    <= proc_v_d;
      cnt_q       <= cnt_d;
      pend_v_q    <= pend_v_d;
      drop_q      <= drop_d;
      res_q       <= res_d;
      cur_q       <= cur_d;
      proc_idx_q  <= proc_idx_d;
      pend_key_q  <= pend_key_d;
      pend_hist_q <= pend_hist_d;
    end
  end

  // Per-entry valid bits give the all-zero reset and the all-at-once clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem[raddr];
      rvld_q  <= vld_q[raddr];
    end
  end

endmodule

/* rtl/key_history_change_reporter_top.sv */
// ----------------------------------------------------------------------------
// Key history change reporter: top level
// Four-bit per-key press history with change reports on ticks.
// ----------------------------------------------------------------------------
// Usage:
// A command beat (func_i, key_i) is taken on a rising edge with start high
// and busy low. Press and release update bit 0 of one key's history; tick
// reports the keys whose history is neither all ones nor all zeros and then
// shifts every history; read returns one history; clear zeroes everything.
// Commands first pass a two-entry queue, so busy only rises when that queue
// is full and the back part is still working on an earlier command.
// Each result beat appears for exactly one cycle with result_valid_o high;
// the receiver cannot hold it off, so it must sample every such cycle.
// last_o marks the final beat of a command; overflow_o on the last report
// says that further changed keys were left out.
// A tick reports only if a press or release changed a history since the last
// tick or clear. Press and release each read and may write one history in the
// back part; a read beat comes from the result register after the memory read
// (straight from the idle state for a key past the end); a tick walks the
// history memory at one key per cycle on its single read port.
// Reset clears the queue, the changed flag and all history valid bits at
// once, so every key reads as zero right after reset.
// ----------------------------------------------------------------------------
module key_history_change_reporter_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [kh_pkg::FUNC_W-1:0] func_i,
  input  logic [kh_pkg::KEY_W-1:0]  key_i,
  output logic                      result_valid_o,
  output logic                      kind_o,
  output logic [kh_pkg::KEY_W-1:0]  key_index_o,
  output logic [kh_pkg::HIST_W-1:0] history_o,
  output logic                      level_o,
  output logic                      overflow_o,
  output logic                      last_o
);

  // Queue between the classifier and the executing engine.
  logic         q_valid;
  logic         q_pop;
  kh_pkg::cmd_t q_cmd;
  kh_pkg::res_t res;

  kh_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .func_i    (func_i),
    .key_i     (key_i),
    .busy_o    (busy),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  kh_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .res_o     (res)
  );

  // The result register in the back part drives the ports directly; the level
  // is simply the current bit of the reported history.
  assign result_valid_o = res.valid;
  assign kind_o         = res.kind;
  assign key_index_o    = res.key;
  assign history_o      = res.hist;
  assign level_o        = res.hist[0];
  assign overflow_o     = res.ovf;
  assign last_o         = res.last;

endmodule

/* rtl/kh_checker.sv */
// ----------------------------------------------------------------------------
// Key history change reporter: port checker
// Watches the result beats of the top level and flags inconsistent ones.
// ----------------------------------------------------------------------------
`include "key_history_change_reporter_top_defines.svh"

module kh_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      res_valid_i,
  input logic                      kind_i,
  input logic [kh_pkg::HIST_W-1:0] history_i,
  input logic                      level_i,
  input logic                      overflow_i,
  input logic                      last_i
);

  `KH_ASSERT(a_level_matches, res_valid_i |-> (level_i == history_i[0]), "level differs from history bit 0")
  `KH_ASSERT(a_overflow_last, (res_valid_i && overflow_i) |-> last_i, "overflow on a beat that is not last")
  `KH_ASSERT(a_read_single, (res_valid_i && kind_i) |-> (last_i && !overflow_i), "read beat not last or with overflow")
  `KH_ASSERT(a_report_changing, (res_valid_i && !kind_i) |-> ((history_i != kh_pkg::HIST_ALL) && (history_i != kh_pkg::HIST_NONE)), "report of a steady key")
  `KH_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !res_valid_i, "result beat during reset")

endmodule

bind key_history_change_reporter_top kh_checker u_kh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_valid_o),
  .kind_i      (kind_o),
  .history_i   (history_o),
  .level_i     (level_o),
  .overflow_i  (overflow_o),
  .last_i      (last_o)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key history change reporter: testbench
// Sends press, release, tick, read, clear and undefined codes in bursts.
// A shadow copy of the key histories predicts every result beat, and each
// beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import kh_pkg::*;

  // Command codes past clear are undefined and must leave the block untouched.
  localparam logic [FUNC_W-1:0] FUNC_RSVD_FIRST = FUNC_CLEAR + 1'b1;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_LAST  = '1;

  localparam int KEY_MAX       = (1 << KEY_W) - 1;
  localparam int TRAFFIC_ITEMS = 180;
  // A tick walks every key once; this covers it with some margin.
  localparam int SETTLE_CYCLES = KEYS + 10;
  // Two queued ticks plus the longest sender pause stay well below this.
  localparam int QUIET_LIMIT   = 3000;

  // One expected result beat.
  typedef struct {
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic [HIST_W-1:0] hist;
    logic              level;
    logic              ovf;
    logic              last;
  } result_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] func = '0;
  logic [KEY_W-1:0]  key = '0;
  logic              result_valid;
  logic              kind;
  logic [KEY_W-1:0]  key_index;
  logic [HIST_W-1:0] history;
  logic              level;
  logic              overflow;
  logic              last;

  // Shadow state of the block, updated as each command is accepted.
  logic [HIST_W-1:0] shadow_hist [KEYS];
  logic              shadow_changed;

  result_beat_t      pending_beats [$];
  result_beat_t      oldest;
  int                errors = 0;
  int                quiet_cycles = 0;
  int                burst_left = 0;
  int                traffic_items = 0;

  key_history_change_reporter_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func),
    .key_i          (key),
    .result_valid_o (result_valid),
    .kind_o         (kind),
    .key_index_o    (key_index),
    .history_o      (history),
    .level_o        (level),
    .overflow_o     (overflow),
    .last_o         (last)
  );

  always #10 clk_i = ~clk_i;

  // Appends one predicted beat to the end of the queue.
  task automatic push_beat(input logic k, input logic [KEY_W-1:0] idx,
                           input logic [HIST_W-1:0] h, input logic lst);
    result_beat_t b;
    b.kind  = k;
    b.key   = idx;
    b.hist  = h;
    b.level = h[0];
    b.ovf   = 1'b0;
    b.last  = lst;
    pending_beats.push_back(b);
  endtask

  // Applies one accepted command to the shadow state and queues its beats.
  task automatic predict_command(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
    bit in_range;
    bit dropped;
    int reported;
    in_range = (k < KEYS);
    case (f)
      FUNC_PRESS: begin
        if (in_range && !shadow_hist[k][0]) begin
          shadow_hist[k][0] = 1'b1;
          shadow_changed = 1'b1;
        end
      end
      FUNC_RELEASE: begin
        if (in_range && shadow_hist[k][0]) begin
          shadow_hist[k][0] = 1'b0;
          shadow_changed = 1'b1;
        end
      end
      FUNC_TICK: begin
        reported = 0;
        dropped = 0;
        if (shadow_changed) begin
          // Report histories that are still moving, lowest key first.
          for (int i = 0; i < KEYS; i++) begin
            if (shadow_hist[i] != HIST_ALL && shadow_hist[i] != HIST_NONE) begin
              if (reported >= MAX_PAIRS) begin
                dropped = 1;
                break;
              end
              push_beat(KIND_REPORT, KEY_W'(i), shadow_hist[i], 1'b0);
              reported++;
            end
          end
          if (reported > 0) begin
            pending_beats[pending_beats.size() - 1].last = 1'b1;
            pending_beats[pending_beats.size() - 1].ovf  = dropped;
          end
          shadow_changed = 1'b0;
        end
        // Age every history and keep the current level in bit 0.
        for (int i = 0; i < KEYS; i++) begin
          shadow_hist[i] = {shadow_hist[i][HIST_W-2:0], shadow_hist[i][0]};
        end
      end
      FUNC_READ: begin
        push_beat(KIND_READ, k, in_range ? shadow_hist[k] : HIST_NONE, 1'b1);
      end
      FUNC_CLEAR: begin
        foreach (shadow_hist[i]) shadow_hist[i] = HIST_NONE;
        shadow_changed = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Sends one command beat. Bursts of random length are separated by random
  // gaps; start stays high from one beat to the next inside a burst.
  task automatic send_command(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
    @(negedge clk_i);
    start <= 1'b1;
    func  <= f;
    key   <= k;
    do @(posedge clk_i); while (busy);
    predict_command(f, k);
    burst_left--;
  endtask

  // Holds the sender off until every predicted beat has arrived, then lets a
  // tick that reports nothing finish its walk.
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    burst_left = 0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Every result beat is taken at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid) begin
      if (pending_beats.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, got key %0d kind %0d",
                 $time, key_index, kind);
        errors++;
      end else begin
        oldest = pending_beats.pop_front();
        check_field("kind", oldest.kind, kind);
        check_field("key_index", oldest.key, key_index);
        check_field("history", oldest.hist, history);
        check_field("level", oldest.level, level);
        check_field("overflow", oldest.ovf, overflow);
        check_field("last", oldest.last, last);
      end
    end
  end

  // A run where neither side moves for too long has hung.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Right after reset every key reads as zero, including keys past the end,
  // and a tick with nothing changed reports nothing.
  task automatic test_reset_state();
    send_command(FUNC_READ, '0);
    send_command(FUNC_READ, KEY_W'(KEYS - 1));
    send_command(FUNC_READ, KEY_W'(KEY_MAX));
    send_command(FUNC_TICK, '0);
  endtask

  // Presses and releases at both ends of the key range; repeated presses and
  // keys past the end must not raise the changed flag or touch a history.
  task automatic test_press_release();
    send_command(FUNC_PRESS, '0);
    send_command(FUNC_PRESS, KEY_W'(KEYS - 1));
    send_command(FUNC_PRESS, '0);
    send_command(FUNC_PRESS, KEY_W'(KEY_MAX));
    send_command(FUNC_RELEASE, KEY_W'(KEYS));
    send_command(FUNC_TICK, '0);
    send_command(FUNC_READ, '0);
    send_command(FUNC_RELEASE, KEY_W'(KEYS - 1));
    send_command(FUNC_TICK, KEY_W'(KEY_MAX));
    send_command(FUNC_READ, KEY_W'(KEYS - 1));
  endtask

  // A press undone before the tick raises the flag but leaves nothing to
  // report; the tick still clears the flag.
  task automatic test_flag_without_report();
    send_command(FUNC_PRESS, 8'd5);
    send_command(FUNC_RELEASE, 8'd5);
    send_command(FUNC_TICK, '0);
    send_command(FUNC_READ, 8'd5);
  endtask

  // Undefined codes are dropped without any beat or state change.
  task automatic test_undefined_codes();
    for (int f = FUNC_RSVD_FIRST; f <= FUNC_RSVD_LAST; f++) begin
      send_command(FUNC_W'(f), (f[0]) ? '0 : KEY_W'(KEY_MAX));
    end
    send_command(FUNC_READ, '0);
  endtask

  task automatic test_clear();
    send_command(FUNC_CLEAR, '0);
    send_command(FUNC_READ, '0);
  endtask

  // Presses a run of neighboring keys and ticks, so that many keys report at
  // once; runs longer than MAX_PAIRS end in an overflow mark.
  task automatic press_run(input int min_run);
    int run;
    int base;
    if ($urandom_range(0, 1)) begin
      send_command(FUNC_CLEAR, KEY_W'($urandom));
      traffic_items++;
    end
    run  = $urandom_range(min_run, MAX_PAIRS + 4);
    base = $urandom_range(0, KEYS - 1);
    for (int i = 0; i < run; i++) begin
      send_command(FUNC_PRESS, KEY_W'((base + i) % KEYS));
      traffic_items++;
    end
    send_command(FUNC_TICK, KEY_W'($urandom));
    traffic_items++;
  endtask

  // Mostly short press and release sequences closed by a tick, mixed with
  // key floods, reads, clears and commands with random codes and keys.
  task automatic test_random_traffic();
    int pick;
    int base;
    bit paused;
    logic [FUNC_W-1:0] f;
    logic [KEY_W-1:0] k;
    paused = 0;
    press_run(MAX_PAIRS + 1);
    while (traffic_items < TRAFFIC_ITEMS) begin
      if (!paused && traffic_items >= TRAFFIC_ITEMS / 2) begin
        paused = 1;
        wait_idle();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        base = $urandom_range(0, KEYS - 8);
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 7) == 0) begin
            k = KEY_W'($urandom_range(KEYS, KEY_MAX));
          end else begin
            k = KEY_W'(base + $urandom_range(0, 7));
          end
          f = $urandom_range(0, 1) ? FUNC_PRESS : FUNC_RELEASE;
          send_command(f, k);
          traffic_items++;
        end
        if ($urandom_range(0, 2) == 0) begin
          send_command(FUNC_READ, KEY_W'(base + $urandom_range(0, 7)));
          traffic_items++;
        end
        send_command(FUNC_TICK, KEY_W'($urandom));
        traffic_items++;
      end else if (pick < 68) begin
        press_run(MAX_PAIRS - 2);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) begin
          f = FUNC_W'($urandom_range(0, FUNC_RSVD_LAST));
          send_command(f, KEY_W'($urandom));
          if (f <= FUNC_CLEAR) traffic_items++;
        end
      end else if (pick < 90) begin
        send_command(FUNC_CLEAR, KEY_W'($urandom));
        traffic_items++;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_command(FUNC_READ, KEY_W'($urandom_range(0, KEY_MAX)));
          traffic_items++;
        end
      end
    end
  endtask

  initial begin
    // The falling reset edge at time zero resets the block before any clock.
    rst_ni <= 1'b0;
    foreach (shadow_hist[i]) shadow_hist[i] = HIST_NONE;
    shadow_changed = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_press_release();
    test_flag_without_report();
    test_undefined_codes();
    test_clear();
    test_random_traffic();

    // All commands are in; let the last beats and any silent tick drain.
    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* key_history_change_reporter_top.f */
+incdir+rtl
rtl/kh_pkg.sv
rtl/kh_front.sv
rtl/kh_back.sv
rtl/key_history_change_reporter_top.sv
rtl/kh_checker.sv
test/tb.sv
